>>> design/iff_pkg.sv
// Package for the integer field formatter: sizes, character codes, mode codes,
// the request and status structs, and the digit to character helpers.
// Depends on nothing; every module of the formatter imports it.
`default_nettype none

package iff_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 11;
  localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int MAX_FIELD  = 31;
  localparam int FCNT_W     = $clog2(2 * MAX_FIELD + 3);

  localparam logic [1:0] RADIX_DEC  = 2'd0;
  localparam logic [1:0] RADIX_OCT  = 2'd1;
  localparam logic [1:0] RADIX_HEXL = 2'd2;
  localparam logic [1:0] RADIX_HEXU = 2'd3;

  localparam logic [2:0] FLAG_NONE  = 3'd0;
  localparam logic [2:0] FLAG_LEFT  = 3'd1;
  localparam logic [2:0] FLAG_PLUS  = 3'd2;
  localparam logic [2:0] FLAG_SPACE = 3'd3;
  localparam logic [2:0] FLAG_ALT   = 3'd4;
  localparam logic [2:0] FLAG_ZPAD  = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_CASE  = 8'h20;

  typedef struct packed {
    logic       neg;
    logic       nz;
    logic [1:0] radix;
    logic [2:0] flag;
    logic [4:0] width;
    logic [5:0] prec;
  } item_t;

  typedef struct packed {
    logic             ready;
    logic [DIG_W-1:0] ndig;
    logic [3:0]       top_digit;
  } conv_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c, input logic upper);
    logic [7:0] r;
    r = c;
    if (upper && (((c >= CH_LA) && (c <= CH_LF)) || (c == CH_LX))) begin
      r = c - CH_CASE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/iff_digit_conv.sv
// Digit converter: a shift-and-add-3 register turns the magnitude into decimal
// digits one bit per cycle; octal and hex digits load directly. Leading zeros
// are then shifted out one digit per cycle. Depends on iff_pkg.
`default_nettype none

module iff_digit_conv import iff_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [VALUE_W-1:0] mag,
  input  wire logic [1:0]         radix,
  input  wire logic               shift,
  output conv_stat_t              stat
);

  typedef enum logic [1:0] {C_IDLE, C_DABBLE, C_NORM, C_HOLD} cstate_t;

  cstate_t                    state;
  logic [NUM_DIGITS-1:0][3:0] digits;
  logic [VALUE_W-1:0]         mag_sr;
  logic [CNT_W-1:0]           bit_cnt;
  logic [DIG_W-1:0]           ndig;

  logic [NUM_DIGITS-1:0][3:0] adj;
  logic [4*NUM_DIGITS:0]      flat;
  logic [NUM_DIGITS-1:0][3:0] load_digits;
  logic [3*NUM_DIGITS-1:0]    mag_oct;
  logic [4*NUM_DIGITS-1:0]    mag_hex;
  logic                       bcd_ok;

  always_comb begin
    mag_oct = (3*NUM_DIGITS)'(mag);
    mag_hex = (4*NUM_DIGITS)'(mag);
    bcd_ok  = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
      bcd_ok = bcd_ok && (digits[i] <= 4'd9);
      if (radix == RADIX_OCT) begin
        load_digits[i] = {1'b0, mag_oct[3*i +: 3]};
      end else begin
        load_digits[i] = mag_hex[4*i +: 4];
      end
    end
    flat = {adj, mag_sr[VALUE_W-1]};
  end

  assign stat.ready     = (state == C_HOLD);
  assign stat.ndig      = ndig;
  assign stat.top_digit = digits[NUM_DIGITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else if (start) begin
      ndig <= DIG_W'(NUM_DIGITS);
      if (radix == RADIX_DEC) begin
        digits  <= '0;
        mag_sr  <= mag;
        bit_cnt <= CNT_W'(VALUE_W - 1);
        state   <= C_DABBLE;
      end else begin
        digits <= load_digits;
        state  <= C_NORM;
      end
    end else begin
      unique case (state)
        C_IDLE: begin
        end
        C_DABBLE: begin
          digits  <= flat[4*NUM_DIGITS-1:0];
          mag_sr  <= {mag_sr[VALUE_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - CNT_W'(1);
          if (bit_cnt == '0) begin
            state <= C_NORM;
          end
        end
        C_NORM: begin
          if ((digits[NUM_DIGITS-1] == 4'd0) && (ndig > DIG_W'(1))) begin
            digits <= {digits[NUM_DIGITS-2:0], 4'd0};
            ndig   <= ndig - DIG_W'(1);
          end else begin
            state <= C_HOLD;
          end
        end
        C_HOLD: begin
          if (shift) begin
            digits <= {digits[NUM_DIGITS-2:0], 4'd0};
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
    stat.ready |-> (ndig != '0) && (ndig <= DIG_W'(NUM_DIGITS)))
    else $error("digit count out of range while digits are offered");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(stat.ready) |-> (digits[NUM_DIGITS-1] != 4'd0) || (ndig == DIG_W'(1)))
    else $error("leading zero left after normalization");

  a_bcd_valid: assert property (@(posedge clk) disable iff (rst)
    (state == C_DABBLE) |-> bcd_ok)
    else $error("decimal digit above nine during conversion");

endmodule

`default_nettype wire

>>> design/iff_emitter.sv
// Field sequencer: plans pad, prefix, zero and digit counts once the digits
// are ready, then sends one character per cycle, as out_ready allows,
// through an output register. Depends on iff_pkg and iff_digit_conv status.
`default_nettype none

module iff_emitter import iff_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire item_t      item,
  input  wire conv_stat_t stat,
  output logic            idle,
  output logic            shift,
  output logic [7:0]      char_out,
  output logic            last,
  output logic            out_valid,
  input  wire logic       out_ready
);

  typedef enum logic [1:0] {E_IDLE, E_WAIT, E_EMIT} estate_t;

  estate_t           state;
  item_t             itm;
  logic [FCNT_W-1:0] lpad;
  logic [1:0]        pcnt;
  logic [7:0]        pre0;
  logic [7:0]        pre1;
  logic [FCNT_W-1:0] zcnt;
  logic [DIG_W-1:0]  dcnt;
  logic [FCNT_W-1:0] rpad;
  logic [FCNT_W-1:0] remaining;

  logic [FCNT_W-1:0] w_sat, p_sat, ndig_f, zeros_base, body, extra, npre_f;
  logic              prec_given;
  logic [1:0]        npre;
  logic [7:0]        p0, p1, ch;
  logic              emit_fire;
  logic [FCNT_W+1:0] seg_sum;

  always_comb begin
    w_sat = (FCNT_W'(itm.width) > FCNT_W'(MAX_FIELD)) ? FCNT_W'(MAX_FIELD)
                                                      : FCNT_W'(itm.width);
    p_sat = (FCNT_W'(itm.prec[4:0]) > FCNT_W'(MAX_FIELD)) ? FCNT_W'(MAX_FIELD)
                                                          : FCNT_W'(itm.prec[4:0]);
    prec_given = !itm.prec[5];
    ndig_f     = FCNT_W'(stat.ndig);
    npre = 2'd0;
    p0   = CH_ZERO;
    p1   = CH_LX;
    if (itm.radix == RADIX_DEC) begin
      if (itm.neg) begin
        npre = 2'd1;
        p0   = CH_MINUS;
      end else if (itm.nz && (itm.flag == FLAG_PLUS)) begin
        npre = 2'd1;
        p0   = CH_PLUS;
      end else if (itm.nz && (itm.flag == FLAG_SPACE)) begin
        npre = 2'd1;
        p0   = CH_SPACE;
      end
    end else if (itm.flag == FLAG_ALT) begin
      npre = (itm.radix == RADIX_OCT) ? 2'd1 : 2'd2;
    end
    npre_f     = FCNT_W'(npre);
    zeros_base = (prec_given && (p_sat > ndig_f)) ? p_sat - ndig_f : '0;
    body       = npre_f + zeros_base + ndig_f;
    extra      = (w_sat > body) ? w_sat - body : '0;

    priority if (lpad != '0) begin
      ch = CH_SPACE;
    end else if (pcnt != 2'd0) begin
      ch = pre0;
    end else if (zcnt != '0) begin
      ch = CH_ZERO;
    end else if (dcnt != '0) begin
      ch = digit_char(stat.top_digit);
    end else begin
      ch = CH_SPACE;
    end

    emit_fire = (state == E_EMIT) && (!out_valid || out_ready);
    shift = emit_fire && (lpad == '0) && (pcnt == 2'd0) && (zcnt == '0) && (dcnt != '0);
    seg_sum = (FCNT_W+2)'(lpad) + (FCNT_W+2)'(pcnt) + (FCNT_W+2)'(zcnt)
            + (FCNT_W+2)'(dcnt) + (FCNT_W+2)'(rpad);
  end

  assign idle = (state == E_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        E_IDLE: begin
          if (start) begin
            itm   <= item;
            state <= E_WAIT;
          end
        end
        E_WAIT: begin
          if (stat.ready) begin
            pcnt      <= npre;
            pre0      <= p0;
            pre1      <= p1;
            dcnt      <= stat.ndig;
            remaining <= body + extra;
            if (itm.flag == FLAG_LEFT) begin
              lpad <= '0;
              rpad <= extra;
              zcnt <= zeros_base;
            end else if (!prec_given && (itm.flag == FLAG_ZPAD)) begin
              lpad <= '0;
              rpad <= '0;
              zcnt <= zeros_base + extra;
            end else begin
              lpad <= extra;
              rpad <= '0;
              zcnt <= zeros_base;
            end
            state <= E_EMIT;
          end
        end
        E_EMIT: begin
          if (emit_fire) begin
            out_valid <= 1'b1;
            char_out  <= to_upper(ch, itm.radix == RADIX_HEXU);
            last      <= (remaining == FCNT_W'(1));
            remaining <= remaining - FCNT_W'(1);
            priority if (lpad != '0) begin
              lpad <= lpad - FCNT_W'(1);
            end else if (pcnt != 2'd0) begin
              pcnt <= pcnt - 2'd1;
              pre0 <= pre1;
            end else if (zcnt != '0) begin
              zcnt <= zcnt - FCNT_W'(1);
            end else if (dcnt != '0) begin
              dcnt <= dcnt - DIG_W'(1);
            end else begin
              rpad <= rpad - FCNT_W'(1);
            end
            if (remaining == FCNT_W'(1)) begin
              state <= E_IDLE;
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    (state == E_EMIT) |-> (seg_sum == (FCNT_W+2)'(remaining)))
    else $error("segment counts disagree with the remaining character count");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && (remaining == FCNT_W'(1))) |=> (state == E_IDLE) && out_valid && last)
    else $error("final character did not close the request");

  a_digit_ready: assert property (@(posedge clk) disable iff (rst)
    shift |-> stat.ready)
    else $error("digit taken before the converter finished");

endmodule

`default_nettype wire

>>> design/integer_field_formatter.sv
// Flow: a decimal request passes through the bit-serial converter and then has
// its leading zeros stripped; octal and hex skip the converter.
// Throughput: one character per cycle unless out_ready stalls it, 1 to 33 characters
// per request; the next request is accepted once the last character has entered
// the output register.
// Reset: synchronous and active high; it empties the output register and idles both units.
`default_nettype none

module integer_field_formatter import iff_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] value,
  input  wire logic [1:0]         radix_mode,
  input  wire logic [2:0]         flag_mode,
  input  wire logic [4:0]         field_width,
  input  wire logic signed [5:0]  min_digits,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              char_out,
  output logic                    last
);

  logic               idle;
  logic               start;
  logic               shift;
  logic [VALUE_W-1:0] uval;
  logic [VALUE_W-1:0] mag;
  item_t              item;
  conv_stat_t         stat;

  always_comb begin
    uval        = VALUE_W'(value);
    item.neg    = (radix_mode == RADIX_DEC) && uval[VALUE_W-1];
    item.nz     = (uval != '0);
    item.radix  = radix_mode;
    item.flag   = flag_mode;
    item.width  = field_width;
    item.prec   = min_digits;
    mag         = item.neg ? ('0 - uval) : uval;
  end

  assign in_ready = idle;
  assign start    = in_valid && in_ready;

  iff_digit_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag),
    .radix (radix_mode),
    .shift (shift),
    .stat  (stat)
  );

  iff_emitter u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .stat      (stat),
    .idle      (idle),
    .shift     (shift),
    .char_out  (char_out),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire
